// File: src/tfsp_pkg.sv
// ============================================================================
// tfsp_pkg
// Shared types and constants for the trust-filtered shortest path unit.
// ============================================================================
package tfsp_pkg;

    localparam int FIELD_NODE_W = 6;
    localparam int LAT_W        = 16;
    localparam int TRUST_W      = 11;
    localparam int PEN_W        = 14;
    localparam int WT_W         = 18;
    localparam int COST_W       = 24;
    localparam int ST_W         = 2;
    localparam int NODE_MAX_W   = 10;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 11;
    localparam int NODES_W      = 7;

    localparam logic [PEN_W-1:0]      PEN_NUM     = 14'd10240;
    localparam logic [COST_W-1:0]     COST_MAX    = 24'hFFFFFF;
    localparam logic [TRUST_W-1:0]    THR_RESET   = 11'd614;
    localparam logic [NODES_W-1:0]    NODES_RESET = 7'd64;

    localparam logic [CFG_IDX_W-1:0]  CFG_TRUST_THR  = 1'b0;
    localparam logic [CFG_IDX_W-1:0]  CFG_NODE_COUNT = 1'b1;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_NO_PATH = 2'd1;
    localparam logic [ST_W-1:0] ST_REJECT  = 2'd2;

    typedef logic [NODE_MAX_W-1:0] t_node;

    // candidate handed down the cell chain during a minimum search
    typedef struct packed {
        logic              have;
        logic [COST_W-1:0] metric;
        t_node             idx;
    } t_token;

    // broadcast from the sequencer to every cell
    typedef struct packed {
        logic              clr;
        logic              settle;
        logic              upd;
        t_node             node;
        logic [COST_W-1:0] metric;
    } t_cell_ctrl;

endpackage

// File: src/tfsp_if.sv
// ============================================================================
// tfsp_in_if / tfsp_out_if
// Valid/ready channels for input items and result items.
// ============================================================================
interface tfsp_in_if;
    logic                                    valid;
    logic                                    ready;
    logic                                    op;
    logic [tfsp_pkg::FIELD_NODE_W-1:0]       from_node;
    logic [tfsp_pkg::FIELD_NODE_W-1:0]       to_node;
    logic [tfsp_pkg::LAT_W-1:0]              latency;
    logic [tfsp_pkg::LAT_W-1:0]              link_cost;
    logic [tfsp_pkg::TRUST_W-1:0]            trust;

    modport source (output valid, op, from_node, to_node, latency, link_cost, trust,
                    input ready);
    modport sink   (input valid, op, from_node, to_node, latency, link_cost, trust,
                    output ready);
endinterface

interface tfsp_out_if;
    logic                         valid;
    logic                         ready;
    logic [tfsp_pkg::ST_W-1:0]    status;
    logic [tfsp_pkg::COST_W-1:0]  path_cost;

    modport source (output valid, status, path_cost, input ready);
    modport sink   (input valid, status, path_cost, output ready);
endinterface

// File: src/trust_filtered_shortest_path_unit.sv
// ============================================================================
// trust_filtered_shortest_path_unit
// Edge store plus Dijkstra search over a chain of node cells.
// ============================================================================
// Add: the source's edge count is read, the penalty divider runs, then the
//   edge and the new count are written and the result is posted.
// Query: per settled node a minimum search down the cell chain, then one edge
//   memory read and relax per outgoing edge of that node. One item is worked at a time.
// A finished result waits in the output register while the next item enters.
// Reset: synchronous, active low; clears control, edge counts and registers
//   to their defaults. The edge memory is not cleared and needs no pass.
module trust_filtered_shortest_path_unit #(
    parameter int MAX_NODES     = 64,
    parameter int MAX_OUT_EDGES = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    tfsp_in_if.sink                           i_item,
    tfsp_out_if.source                        o_result,
    input  logic                              i_cfg_we,
    input  logic [tfsp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [tfsp_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    localparam int NODE_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CNT_W  = $clog2(MAX_NODES + 1);
    localparam int ECNT_W = $clog2(MAX_OUT_EDGES + 1);
    localparam int DEPTH  = MAX_NODES * MAX_OUT_EDGES;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    // edge entry: {dest, weight, trust}
    localparam int E_W    = NODE_W + tfsp_pkg::WT_W + tfsp_pkg::TRUST_W;
    localparam int E_TR_L = 0;
    localparam int E_WT_L = tfsp_pkg::TRUST_W;
    localparam int E_DS_L = tfsp_pkg::TRUST_W + tfsp_pkg::WT_W;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_ACNT = 9'b000000010,
        S_ADIV = 9'b000000100,
        S_QCLR = 9'b000001000,
        S_SRCH = 9'b000010000,
        S_QCNT = 9'b000100000,
        S_QRD  = 9'b001000000,
        S_QREL = 9'b010000000,
        S_RESP = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // configuration
    logic [tfsp_pkg::TRUST_W-1:0]  r_thr;
    logic [tfsp_pkg::NODES_W-1:0]  r_nodes;
    logic [CNT_W-1:0]              w_n;

    // latched item
    logic [tfsp_pkg::FIELD_NODE_W-1:0]   r_from;
    logic [tfsp_pkg::FIELD_NODE_W-1:0]   r_to;
    logic [tfsp_pkg::LAT_W-1:0]          r_lat;
    logic [tfsp_pkg::LAT_W-1:0]          r_cost;
    logic [tfsp_pkg::TRUST_W-1:0]        r_trust;

    // pending result and output register
    logic [tfsp_pkg::ST_W-1:0]    r_pst;
    logic [tfsp_pkg::COST_W-1:0]  r_pcost;
    logic                         r_out_valid;
    logic [tfsp_pkg::ST_W-1:0]    r_out_st;
    logic [tfsp_pkg::COST_W-1:0]  r_out_cost;

    // edge counts: memory plus a valid bit per node
    logic [ECNT_W-1:0]     cnt_mem [MAX_NODES];
    logic [MAX_NODES-1:0]  r_cnt_vld;
    logic [ECNT_W-1:0]     r_cnt_q;
    logic                  r_cnt_vq;
    logic [NODE_W-1:0]     w_cnt_ra;
    logic [ECNT_W-1:0]     w_cur_cnt;
    logic [ECNT_W-1:0]     r_ecnt;

    // edge store
    logic [E_W-1:0]        edge_mem [DEPTH];
    logic [E_W-1:0]        r_edge_q;
    logic [ADDR_W-1:0]     w_e_ra;
    logic [ADDR_W-1:0]     w_e_wa;
    logic                  w_e_we;
    logic [E_W-1:0]        w_e_wd;

    // search
    logic [CNT_W-1:0]             r_scnt;
    logic [NODE_W-1:0]            r_best;
    logic [tfsp_pkg::COST_W-1:0]  r_bdist;
    logic [ECNT_W-1:0]            r_slot;
    tfsp_pkg::t_token             w_tok [MAX_NODES+1];
    tfsp_pkg::t_token             w_best;
    tfsp_pkg::t_cell_ctrl         w_ctrl;
    logic                         w_srch_end;
    logic                         w_is_dst;

    // relaxation
    logic [NODE_W-1:0]             w_e_dest;
    logic [tfsp_pkg::WT_W-1:0]     w_e_wt;
    logic [tfsp_pkg::TRUST_W-1:0]  w_e_tr;
    logic [tfsp_pkg::COST_W:0]     w_nd_sum;
    logic [tfsp_pkg::COST_W-1:0]   w_nd;
    logic                          w_e_use;

    // add path
    logic                          w_in_acc;
    logic                          w_reject;
    logic                          w_q_range;
    logic                          w_div_start;
    logic                          w_div_done;
    logic [tfsp_pkg::PEN_W-1:0]    w_quot;
    logic                          w_last_edge;

    assign w_in_acc = i_item.valid && i_item.ready;
    assign i_item.ready = (r_state == S_IDLE);

    // node count in use, capped at the cell count
    assign w_n = (int'(r_nodes) > MAX_NODES) ? CNT_W'(MAX_NODES) : CNT_W'(r_nodes);

    assign w_cur_cnt = r_cnt_vq ? r_cnt_q : '0;
    assign w_reject  = (int'(r_from) >= MAX_NODES) || (int'(r_to) >= MAX_NODES) ||
                       (int'(w_cur_cnt) >= MAX_OUT_EDGES);
    assign w_q_range = (int'(i_item.from_node) < int'(w_n)) &&
                       (int'(i_item.to_node) < int'(w_n));
    assign w_div_start = (r_state == S_ACNT) && !w_reject;
    assign w_last_edge = (ECNT_W'(r_slot + ECNT_W'(1)) == r_ecnt);

    // chain head carries no candidate
    assign w_tok[0]   = '0;
    assign w_best     = w_tok[MAX_NODES];
    assign w_srch_end = (r_state == S_SRCH) && (r_scnt == CNT_W'(MAX_NODES));
    assign w_is_dst   = (w_best.idx == tfsp_pkg::NODE_MAX_W'(r_to));

    // count memory is read at the input source node, or at the search winner
    assign w_cnt_ra = (r_state == S_SRCH) ? NODE_W'(w_best.idx) : NODE_W'(i_item.from_node);

    assign w_e_ra = ADDR_W'(int'(r_best) * MAX_OUT_EDGES + int'(r_slot));
    assign w_e_wa = ADDR_W'(int'(NODE_W'(r_from)) * MAX_OUT_EDGES + int'(r_ecnt));
    assign w_e_we = (r_state == S_ADIV) && w_div_done;
    assign w_e_wd = {NODE_W'(r_to),
                     tfsp_pkg::WT_W'(r_lat) + tfsp_pkg::WT_W'(r_cost) +
                         tfsp_pkg::WT_W'(w_quot),
                     r_trust};

    assign w_e_dest = r_edge_q[E_DS_L +: NODE_W];
    assign w_e_wt   = r_edge_q[E_WT_L +: tfsp_pkg::WT_W];
    assign w_e_tr   = r_edge_q[E_TR_L +: tfsp_pkg::TRUST_W];
    assign w_e_use  = (w_e_tr >= r_thr) && (int'(w_e_dest) < int'(w_n));
    assign w_nd_sum = {1'b0, r_bdist} + (tfsp_pkg::COST_W + 1)'(w_e_wt);
    // saturate the path sum
    assign w_nd     = w_nd_sum[tfsp_pkg::COST_W] ? tfsp_pkg::COST_MAX
                                                 : w_nd_sum[tfsp_pkg::COST_W-1:0];

    // broadcast to the cells: clear at query start, settle the winner,
    // relax one edge
    always_comb begin
        w_ctrl = '0;
        case (r_state)
            S_QCLR: begin
                w_ctrl.clr  = 1'b1;
                w_ctrl.node = tfsp_pkg::NODE_MAX_W'(r_from);
            end
            S_SRCH: begin
                w_ctrl.settle = w_srch_end && w_best.have && !w_is_dst;
                w_ctrl.node   = w_best.idx;
            end
            S_QREL: begin
                w_ctrl.upd    = w_e_use;
                w_ctrl.node   = tfsp_pkg::NODE_MAX_W'(w_e_dest);
                w_ctrl.metric = w_nd;
            end
            default: begin
                w_ctrl = '0;
            end
        endcase
    end

    genvar g;
    generate
        for (g = 0; g < MAX_NODES; g++) begin : g_cell
            tfsp_cell #(.IDX(g)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctrl  (w_ctrl),
                .i_tok   (w_tok[g]),
                .o_tok   (w_tok[g+1])
            );
        end
    endgenerate

    tfsp_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_div_start),
        .i_divisor (r_trust),
        .o_done    (w_div_done),
        .o_quot    (w_quot)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (i_item.op == tfsp_pkg::OP_ADD) n_state = S_ACNT;
                    else if (w_q_range)                n_state = S_QCLR;
                    else                               n_state = S_RESP;
                end
            end
            S_ACNT: n_state = w_reject ? S_RESP : S_ADIV;
            S_ADIV: if (w_div_done) n_state = S_RESP;
            S_QCLR: n_state = S_SRCH;
            S_SRCH: begin
                if (w_srch_end) n_state = (w_best.have && !w_is_dst) ? S_QCNT : S_RESP;
            end
            S_QCNT: n_state = (w_cur_cnt == '0) ? S_SRCH : S_QRD;
            S_QRD:  n_state = S_QREL;
            S_QREL: n_state = w_last_edge ? S_SRCH : S_QRD;
            S_RESP: if (!r_out_valid || o_result.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // memories
    always_ff @(posedge i_clk) begin
        r_cnt_q  <= cnt_mem[w_cnt_ra];
        r_edge_q <= edge_mem[w_e_ra];
        if (w_e_we) begin
            edge_mem[w_e_wa] <= w_e_wd;
            cnt_mem[NODE_W'(r_from)] <= ECNT_W'(r_ecnt + ECNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_thr       <= tfsp_pkg::THR_RESET;
            r_nodes     <= tfsp_pkg::NODES_RESET;
            r_out_valid <= 1'b0;
            r_cnt_vld   <= '0;
            r_cnt_vq    <= 1'b0;
            r_scnt      <= '0;
        end else begin
            r_state  <= n_state;
            r_cnt_vq <= r_cnt_vld[w_cnt_ra];

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    tfsp_pkg::CFG_TRUST_THR:  r_thr   <= i_cfg_data;
                    tfsp_pkg::CFG_NODE_COUNT: r_nodes <= i_cfg_data[tfsp_pkg::NODES_W-1:0];
                    default: ;
                endcase
            end

            // drop the taken beat; the response state reloads it itself
            if (o_result.ready && (r_state != S_RESP)) r_out_valid <= 1'b0;

            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_from  <= i_item.from_node;
                        r_to    <= i_item.to_node;
                        r_lat   <= i_item.latency;
                        r_cost  <= i_item.link_cost;
                        r_trust <= i_item.trust;
                        r_pst   <= tfsp_pkg::ST_NO_PATH;
                        r_pcost <= '0;
                    end
                end
                S_ACNT: begin
                    r_ecnt  <= w_cur_cnt;
                    r_pst   <= w_reject ? tfsp_pkg::ST_REJECT : tfsp_pkg::ST_OK;
                end
                S_ADIV: begin
                    if (w_div_done) r_cnt_vld[NODE_W'(r_from)] <= 1'b1;
                end
                S_QCLR: begin
                    r_scnt <= '0;
                end
                S_SRCH: begin
                    r_scnt <= CNT_W'(r_scnt + CNT_W'(1));
                    if (w_srch_end) begin
                        r_best  <= NODE_W'(w_best.idx);
                        r_bdist <= w_best.metric;
                        if (w_best.have && w_is_dst) begin
                            r_pst   <= tfsp_pkg::ST_OK;
                            r_pcost <= w_best.metric;
                        end
                    end
                end
                S_QCNT: begin
                    r_ecnt <= w_cur_cnt;
                    r_slot <= '0;
                    r_scnt <= '0;
                end
                S_QREL: begin
                    r_slot <= ECNT_W'(r_slot + ECNT_W'(1));
                    r_scnt <= '0;
                end
                S_RESP: begin
                    if (!r_out_valid || o_result.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_st    <= r_pst;
                        r_out_cost  <= r_pcost;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_result.valid     = r_out_valid;
    assign o_result.status    = r_out_st;
    assign o_result.path_cost = r_out_cost;
endmodule

// File: src/tfsp_div.sv
// ============================================================================
// tfsp_div
// Restoring divider: trust penalty 10240 / trust, one quotient bit a cycle.
// ============================================================================
module tfsp_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [tfsp_pkg::TRUST_W-1:0]  i_divisor,
    output logic                          o_done,
    output logic [tfsp_pkg::PEN_W-1:0]    o_quot
);
    logic                          r_busy;
    logic                          r_done;
    logic [3:0]                    r_cnt;
    logic [tfsp_pkg::TRUST_W:0]    r_rem;
    logic [tfsp_pkg::PEN_W-1:0]    r_num;
    logic [tfsp_pkg::PEN_W-1:0]    r_quot;
    logic [tfsp_pkg::TRUST_W-1:0]  r_div;
    logic [tfsp_pkg::TRUST_W:0]    w_sh;
    logic [tfsp_pkg::TRUST_W+1:0]  w_trial;

    assign w_sh    = {r_rem[tfsp_pkg::TRUST_W-1:0], r_num[tfsp_pkg::PEN_W-1]};
    assign w_trial = {1'b0, w_sh} - {2'b00, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_num  <= tfsp_pkg::PEN_NUM;
                // zero trust divides as one
                r_div  <= (i_divisor == '0) ? tfsp_pkg::TRUST_W'(1) : i_divisor;
            end else if (r_busy) begin
                r_num <= {r_num[tfsp_pkg::PEN_W-2:0], 1'b0};
                if (!w_trial[tfsp_pkg::TRUST_W+1]) begin
                    r_rem  <= w_trial[tfsp_pkg::TRUST_W:0];
                    r_quot <= {r_quot[tfsp_pkg::PEN_W-2:0], 1'b1};
                end else begin
                    r_rem  <= w_sh;
                    r_quot <= {r_quot[tfsp_pkg::PEN_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'(tfsp_pkg::PEN_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

// File: src/tfsp_cell.sv
// ============================================================================
// tfsp_cell
// One graph node: distance, reached and settled bits, one stage of the
// minimum-search chain.
// ============================================================================
module tfsp_cell #(
    parameter int IDX = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tfsp_pkg::t_cell_ctrl  i_ctrl,
    input  tfsp_pkg::t_token      i_tok,
    output tfsp_pkg::t_token      o_tok
);
    logic                         r_reached;
    logic                         r_settled;
    logic [tfsp_pkg::COST_W-1:0]  r_dist;
    tfsp_pkg::t_token             r_tok;
    logic                         w_me;
    logic                         w_take;

    assign w_me   = (i_ctrl.node == tfsp_pkg::NODE_MAX_W'(IDX));
    assign w_take = r_reached && !r_settled && (!i_tok.have || r_dist < i_tok.metric);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reached <= 1'b0;
            r_settled <= 1'b0;
            r_tok     <= '0;
        end else begin
            // keep the earlier index on a tie
            if (w_take) begin
                r_tok.have   <= 1'b1;
                r_tok.metric <= r_dist;
                r_tok.idx    <= tfsp_pkg::NODE_MAX_W'(IDX);
            end else begin
                r_tok <= i_tok;
            end
            if (i_ctrl.clr) begin
                r_reached <= w_me;
                r_settled <= 1'b0;
                r_dist    <= '0;
            end else if (i_ctrl.settle && w_me) begin
                r_settled <= 1'b1;
            end else if (i_ctrl.upd && w_me && (!r_reached || i_ctrl.metric < r_dist)) begin
                r_reached <= 1'b1;
                r_dist    <= i_ctrl.metric;
            end
        end
    end

    assign o_tok = r_tok;
endmodule

// File: src/tfsp_checker.sv
// ============================================================================
// tfsp_checker
// Port-level checks on the result channel, bound to the top level.
// ============================================================================
module tfsp_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [tfsp_pkg::ST_W-1:0]     out_status,
    input logic [tfsp_pkg::COST_W-1:0]   out_cost
);
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result beat right after reset");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_status == tfsp_pkg::ST_OK ||
                       out_status == tfsp_pkg::ST_NO_PATH ||
                       out_status == tfsp_pkg::ST_REJECT))
        else $error("unknown status code");

    a_cost_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_status != tfsp_pkg::ST_OK |-> out_cost == '0)
        else $error("nonzero cost on a failed item");
endmodule

bind trust_filtered_shortest_path_unit tfsp_checker u_tfsp_checker (
    .clk        (i_clk),
    .rst_n      (i_rst_n),
    .out_valid  (o_result.valid),
    .out_ready  (o_result.ready),
    .out_status (o_result.status),
    .out_cost   (o_result.path_cost)
);
